### design/bb3_pkg.sv
// shared types, constants and helper functions of the 3x3 box blur
// no dependencies; imported by every module of the block but bb3_ram
`default_nettype none

package bb3_pkg;

    // configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_CFG_W  = 12;
    localparam int HEIGHT_CFG_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int WIDTH_RESET  = 640;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_LIMIT = 13'd4096;

    localparam int DEF_MAX_WIDTH = 2048;

    // pixel and arithmetic widths
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int SUM_W   = 12;              // 9 * 255 fits
    localparam int CNT_W   = 4;               // up to 9 neighbors
    localparam int NUM_W   = SUM_W + 1;       // 2*sum + count
    localparam int RECIP_W = 20;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W  = NUM_W + RECIP_W;

    // input item
    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic            is_padding;
    } t_pix_in;

    // result item
    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            last_of_frame;
    } t_pix_out;

    // per-item position flags, made when the item enters
    typedef struct packed {
        logic emit;       // item completes a result
        logic last;       // result belongs to the frame's final pixel
        logic top_off;    // row above the center lies outside the frame
        logic bot_off;    // row below the center lies outside the frame
        logic left_off;   // column left of the center lies outside
        logic right_off;  // column right of the center lies outside
    } t_pos_flags;

    // one column of the neighborhood after the line store
    typedef struct packed {
        logic [PIX_W-1:0] above2;
        logic [PIX_W-1:0] above1;
        logic [PIX_W-1:0] pix;
        t_pos_flags       flags;
    } t_col_item;

    // masked sums of one neighborhood
    typedef struct packed {
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_sum_item;

    // ceil(2^RECIP_SHIFT / (2*count)) for every count a neighborhood can have
    function automatic logic [RECIP_W-1:0] bb3_recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        unique case (count)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### design/bb3_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies; a read of the address being written returns the old data
`default_nettype none

module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/bb3_scan.sv
// frame geometry registers and raster position counters of the box blur
// depends on bb3_pkg; gives the line store address and position flags of each item
`default_nettype none

module bb3_scan
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                         i_adv,
    output logic      [$clog2(MAX_WIDTH)-1:0] o_addr,
    output t_pos_flags                        o_flags
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int W_RESET_EFF = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [WW-1:0]           r_w, n_w;
    logic [HEIGHT_CFG_W-1:0] r_h, n_h;
    logic [AW-1:0]           r_col, n_col;
    logic [HEIGHT_CFG_W-1:0] r_row, n_row;

    logic [WIDTH_CFG_W-1:0]  w_raw;
    logic [HEIGHT_CFG_W-1:0] h_raw;
    logic [WW-1:0]           w_clamp;
    logic [HEIGHT_CFG_W-1:0] h_clamp;
    logic [WW-1:0]           col_ext;
    logic [WW-1:0]           col_p1;
    logic [HEIGHT_CFG_W-1:0] h_p1;
    logic                    col_nz;

    // clamp written geometry to the supported range
    always_comb begin
        w_raw = i_cfg_data[WIDTH_CFG_W-1:0];
        h_raw = i_cfg_data[HEIGHT_CFG_W-1:0];
        if (w_raw == '0) begin
            w_clamp = WW'(1);
        end else if (32'(w_raw) > MAX_WIDTH) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(w_raw);
        end
        if (h_raw == '0) begin
            h_clamp = HEIGHT_CFG_W'(1);
        end else if (h_raw > HEIGHT_LIMIT) begin
            h_clamp = HEIGHT_LIMIT;
        end else begin
            h_clamp = h_raw;
        end
    end

    // position helpers
    assign col_nz  = (r_col != '0);
    assign col_ext = WW'(r_col);
    assign col_p1  = col_ext + WW'(1);
    assign h_p1    = r_h + HEIGHT_CFG_W'(1);

    // flags of the item at the current position; the center of its result
    // sits one row up and one column left (wrapping to the row before)
    always_comb begin
        o_flags.last      = (r_row == h_p1);
        o_flags.emit      = !((r_row == '0) || ((r_row == HEIGHT_CFG_W'(1)) && !col_nz));
        o_flags.top_off   = col_nz ? (r_row == HEIGHT_CFG_W'(1)) : (r_row == HEIGHT_CFG_W'(2));
        o_flags.bot_off   = col_nz ? (r_row >= r_h) : (r_row >= h_p1);
        o_flags.left_off  = col_nz ? (r_col == AW'(1)) : (r_w == WW'(1));
        o_flags.right_off = !col_nz;
    end

    assign o_addr = r_col;

    // geometry writes restart the frame, accepted items advance it
    always_comb begin
        n_w   = r_w;
        n_h   = r_h;
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            if (i_cfg_idx == REG_IMAGE_WIDTH) begin
                n_w   = w_clamp;
                n_col = '0;
                n_row = '0;
            end else if (i_cfg_idx == REG_IMAGE_HEIGHT) begin
                n_h   = h_clamp;
                n_col = '0;
                n_row = '0;
            end
        end else if (i_adv) begin
            if (o_flags.last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_p1 == r_w) begin
                n_col = '0;
                n_row = r_row + HEIGHT_CFG_W'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= WW'(W_RESET_EFF);
            r_h   <= HEIGHT_RESET;
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_w   <= n_w;
            r_h   <= n_h;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

`ifndef ASSERT_OFF
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        col_ext < r_w)
        else $error("column position beyond frame width");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= h_p1) && ((r_row != h_p1) || !col_nz))
        else $error("row position beyond drain position");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_cfg_we && o_flags.last) |=> (r_row == '0) && (r_col == '0))
        else $error("frame count did not wrap after the last drain item");
`endif

endmodule

`default_nettype wire

### design/bb3_line.sv
// line store stage: reads the two stored rows at the item's column and writes back
// depends on bb3_pkg and bb3_ram; forwards the pending write when columns collide
`default_nettype none

module bb3_line
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire t_pix_in                      i_pix,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  wire t_pos_flags                   i_flags,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output t_col_item                         o_col
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                 r_v;
    logic [AW-1:0]        r_addr;
    logic [PIX_W-1:0]     r_pix;
    t_pos_flags           r_flags;
    logic                 r_fwd;
    logic [2*PIX_W-1:0]   r_fwd_data;

    logic                 accept;
    logic                 move;
    logic [PIX_W-1:0]     pix_in;
    logic [2*PIX_W-1:0]   ram_rdata;
    logic [2*PIX_W-1:0]   rd;
    logic [2*PIX_W-1:0]   wdata;

    assign o_ready = !r_v || i_ready;
    assign accept  = i_valid && o_ready;
    assign move    = r_v && i_ready;

    // padding inside the frame enters as black
    assign pix_in = i_pix.is_padding ? '0
                  : {i_pix.red_in, i_pix.green_in, i_pix.blue_in};

    // entry holds {upper row, middle row}; the write shifts middle up
    assign rd    = r_fwd ? r_fwd_data : ram_rdata;
    assign wdata = {rd[PIX_W-1:0], r_pix};

    bb3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (move),
        .i_waddr (r_addr),
        .i_wdata (wdata),
        .i_re    (accept),
        .i_raddr (i_addr),
        .o_rdata (ram_rdata)
    );

    // stage register; a write landing on the column being read is forwarded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (move) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr     <= i_addr;
            r_pix      <= pix_in;
            r_flags    <= i_flags;
            r_fwd      <= move && (r_addr == i_addr);
            r_fwd_data <= wdata;
        end
    end

    assign o_valid      = r_v;
    assign o_col.above2 = rd[2*PIX_W-1:PIX_W];
    assign o_col.above1 = rd[PIX_W-1:0];
    assign o_col.pix    = r_pix;
    assign o_col.flags  = r_flags;

endmodule

`default_nettype wire

### design/bb3_window.sv
// 3x3 window and masked neighborhood sums of the box blur
// depends on bb3_pkg; drops items that complete no result
`default_nettype none

module bb3_window
    import bb3_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_col_item i_col,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_sum_item      o_sum
);

    logic [PIX_W-1:0] r_win [9];
    logic             r2_v;
    t_pos_flags       r2_flags;
    logic             r3_v;
    t_sum_item        r3_item;

    logic             en3;
    logic             s2_leave;
    logic             load2;
    logic [2:0]       row_in;
    logic [2:0]       col_in;
    logic [1:0]       nrows;
    logic [1:0]       ncols;
    t_sum_item        sum_now;

    assign en3      = !r3_v || i_ready;
    assign s2_leave = !r2_flags.emit || en3;
    assign o_ready  = !r2_v || s2_leave;
    assign load2    = i_valid && o_ready;

    // window shifts left by one column per item; newest column on the right
    always_ff @(posedge i_clk) begin
        if (load2) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3]   <= r_win[k*3+1];
                r_win[k*3+1] <= r_win[k*3+2];
            end
            r_win[2] <= i_col.above2;
            r_win[5] <= i_col.above1;
            r_win[8] <= i_col.pix;
            r2_flags <= i_col.flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (load2) begin
            r2_v <= 1'b1;
        end else if (s2_leave) begin
            r2_v <= 1'b0;
        end
    end

    // masked sums over the neighbors that lie inside the frame
    always_comb begin
        row_in = {!r2_flags.bot_off, 1'b1, !r2_flags.top_off};
        col_in = {!r2_flags.right_off, 1'b1, !r2_flags.left_off};
        sum_now.sum_r = '0;
        sum_now.sum_g = '0;
        sum_now.sum_b = '0;
        for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
                if (row_in[k] && col_in[m]) begin
                    sum_now.sum_r = sum_now.sum_r + SUM_W'(r_win[k*3+m][3*CH_W-1:2*CH_W]);
                    sum_now.sum_g = sum_now.sum_g + SUM_W'(r_win[k*3+m][2*CH_W-1:CH_W]);
                    sum_now.sum_b = sum_now.sum_b + SUM_W'(r_win[k*3+m][CH_W-1:0]);
                end
            end
        end
        nrows = 2'(row_in[0]) + 2'(row_in[1]) + 2'(row_in[2]);
        ncols = 2'(col_in[0]) + 2'(col_in[1]) + 2'(col_in[2]);
        sum_now.count = CNT_W'(nrows) * CNT_W'(ncols);
        sum_now.last  = r2_flags.last;
    end

    // sum register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (r2_v && r2_flags.emit && en3) begin
            r3_v <= 1'b1;
        end else if (i_ready) begin
            r3_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_v && r2_flags.emit && en3) begin
            r3_item <= sum_now;
        end
    end

    assign o_valid = r3_v;
    assign o_sum   = r3_item;

endmodule

`default_nettype wire

### design/bb3_avg.sv
// rounded average of each channel: (2*sum + count) / (2*count)
// depends on bb3_pkg; division by the neighbor count is a reciprocal multiply
`default_nettype none

module bb3_avg
    import bb3_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_sum_item i_sum,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_pix_out       o_pix
);

    logic              r_v;
    logic [PROD_W-1:0] r_prod_r;
    logic [PROD_W-1:0] r_prod_g;
    logic [PROD_W-1:0] r_prod_b;
    logic              r_last;

    logic              load;
    logic [RECIP_W-1:0] recip;
    logic [NUM_W-1:0]  num_r;
    logic [NUM_W-1:0]  num_g;
    logic [NUM_W-1:0]  num_b;

    assign o_ready = !r_v || i_ready;
    assign load    = i_valid && o_ready;

    // numerators with the half-up rounding term
    assign recip = bb3_recip(i_sum.count);
    assign num_r = {i_sum.sum_r, 1'b0} + NUM_W'(i_sum.count);
    assign num_g = {i_sum.sum_g, 1'b0} + NUM_W'(i_sum.count);
    assign num_b = {i_sum.sum_b, 1'b0} + NUM_W'(i_sum.count);

    // output register holds the products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (load) begin
            r_v <= 1'b1;
        end else if (i_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_prod_r <= PROD_W'(num_r) * PROD_W'(recip);
            r_prod_g <= PROD_W'(num_g) * PROD_W'(recip);
            r_prod_b <= PROD_W'(num_b) * PROD_W'(recip);
            r_last   <= i_sum.last;
        end
    end

    assign o_valid             = r_v;
    assign o_pix.red_out       = r_prod_r[RECIP_SHIFT +: CH_W];
    assign o_pix.green_out     = r_prod_g[RECIP_SHIFT +: CH_W];
    assign o_pix.blue_out      = r_prod_b[RECIP_SHIFT +: CH_W];
    assign o_pix.last_of_frame = r_last;

endmodule

`default_nettype wire

### design/box_blur_3x3_edge_clipped_top.sv
// 3x3 box blur with clipped edges over a raster stream of rgb pixels.
// The block takes one item per clock when the output side keeps up: the
// line store is a single two-port memory (MAX_WIDTH entries of both stored
// rows) read when an item is accepted and written back one stage later, so
// its read-modify-write never blocks the next item; for width one the
// pending write is forwarded. Each frame is width*height pixel items and
// then width+1 drain items; the result for a pixel comes with the item
// width+1 places later and leaves four register stages after that item is
// accepted. The first width+1 items of a frame give no result, and the
// frame's final result has last_of_frame set. Writing either geometry
// register restarts the frame count. The store needs no clearing after
// reset, since neighbors outside the frame are masked.
// depends on bb3_pkg, bb3_scan, bb3_line, bb3_window and bb3_avg
`default_nettype none

module box_blur_3x3_edge_clipped_top
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_pix_in               i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_pix_out                   o_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [AW-1:0] scan_addr;
    t_pos_flags    scan_flags;
    logic          line_valid;
    logic          line_ready;
    t_col_item     line_col;
    logic          win_valid;
    logic          win_ready;
    t_sum_item     win_sum;

    // raster position and geometry
    bb3_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_adv      (i_valid && o_ready),
        .o_addr     (scan_addr),
        .o_flags    (scan_flags)
    );

    // line store read-modify-write
    bb3_line #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (i_data),
        .i_addr  (scan_addr),
        .i_flags (scan_flags),
        .o_valid (line_valid),
        .i_ready (line_ready),
        .o_col   (line_col)
    );

    // window and masked sums
    bb3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (line_valid),
        .o_ready (line_ready),
        .i_col   (line_col),
        .o_valid (win_valid),
        .i_ready (win_ready),
        .o_sum   (win_sum)
    );

    // rounded averages and output register
    bb3_avg u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (win_valid),
        .o_ready (win_ready),
        .i_sum   (win_sum),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pix   (o_data)
    );

endmodule

`default_nettype wire

### dv/tb_box_blur_3x3_edge_clipped_top.sv
// self-checking testbench of the 3x3 edge-clipped box blur top level
// a clocked driver, a clocked monitor with its own blur predictor, random idling
// depends on bb3_pkg and box_blur_3x3_edge_clipped_top
`default_nettype none

module tb_box_blur_3x3_edge_clipped_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bb3_pkg::*;

    localparam int unsigned STORE_DEPTH = DEF_MAX_WIDTH;
    localparam int unsigned ROW_CAP     = 4096;
    localparam int          LAT_WAIT    = 16;
    localparam int          LONG_STALL  = 300;
    localparam int unsigned RAND_PIXELS = 100;
    localparam int unsigned CALM_TAIL   = 100;
    localparam int          REPORT_CAP  = 200;
    localparam longint      CYCLE_LIMIT = 2_000_000;

    // register indexes that the block ignores
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // one queued input item, optionally held back until all results are out
    typedef struct {
        t_pix_in pix;
        bit      hold_for_drain;
    } t_feed;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    t_pix_in               i_data     = '0;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    t_pix_out              o_data;

    box_blur_3x3_edge_clipped_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    // stimulus and expectation stores
    t_feed       pixel_feed[$];
    t_pix_out    pending_blur[$];
    t_feed       next_ent;
    int unsigned pixels_queued   = 0;
    int unsigned pixels_accepted = 0;
    int unsigned frame_pixels    = 0;
    int          fail_count      = 0;
    bit          in_fire         = 1'b0;
    bit          calm            = 1'b0;
    int          send_gap        = 0;
    int          stall_left      = 0;
    int          hold_req        = 0;
    int          hold_seen       = 0;
    longint      cycle_count     = 0;

    // predictor state
    logic [PIX_W-1:0]          upper_rows [STORE_DEPTH];
    logic [PIX_W-1:0]          middle_rows[STORE_DEPTH];
    logic [PIX_W-1:0]          win[9];
    int unsigned               col_pos;
    int unsigned               row_pos;
    logic [WIDTH_CFG_W-1:0]    cfg_width;
    logic [HEIGHT_CFG_W-1:0]   cfg_height;

    always #4 i_clk = ~i_clk;

    // advance the blur predictor by one accepted item
    task automatic predict_blur(input t_pix_in item);
        int unsigned w, h, col, row, pos, pos_first, pos_final, rr, cc, cnt;
        int unsigned sr, sg, sb;
        int unsigned k, m;
        logic [PIX_W-1:0] pix, above2, above1, px;
        t_pix_out res;
        w = (cfg_width == 0) ? 1 : ((cfg_width > STORE_DEPTH) ? STORE_DEPTH : cfg_width);
        h = (cfg_height == 0) ? 1 : ((cfg_height > ROW_CAP) ? ROW_CAP : cfg_height);
        if (col_pos >= w || row_pos > h + 1 || (row_pos == h + 1 && col_pos > 0)) begin
            col_pos = 0;
            row_pos = 0;
        end
        col = col_pos;
        row = row_pos;
        pix = item.is_padding ? '0 : {item.red_in, item.green_in, item.blue_in};

        // line stores shift down one row at this column
        above2 = upper_rows[col];
        above1 = middle_rows[col];
        upper_rows[col]  = above1;
        middle_rows[col] = pix;

        // window shifts left, new column enters on the right
        for (k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = above2;
        win[5] = above1;
        win[8] = pix;

        pos       = row * w + col;
        pos_first = w + 1;
        pos_final = w * h + w;
        if (pos == pos_final) begin
            col_pos = 0;
            row_pos = 0;
        end else begin
            col_pos = col + 1;
            if (col_pos == w) begin
                col_pos = 0;
                row_pos = row + 1;
            end
        end
        if (pos < pos_first)
            return;

        // center of the finished neighborhood
        if (col >= 1) begin
            rr = row - 1;
            cc = col - 1;
        end else begin
            rr = row - 2;
            cc = w - 1;
        end

        // masked sums over the neighbors inside the frame
        sr = 0;
        sg = 0;
        sb = 0;
        cnt = 0;
        for (k = 0; k < 3; k++) begin
            if (k == 0 && rr == 0)
                continue;
            if (k == 2 && rr + 1 >= h)
                continue;
            for (m = 0; m < 3; m++) begin
                if (m == 0 && cc == 0)
                    continue;
                if (m == 2 && cc + 1 >= w)
                    continue;
                px = win[k*3+m];
                sr += px[23:16];
                sg += px[15:8];
                sb += px[7:0];
                cnt++;
            end
        end
        res.red_out       = CH_W'((2 * sr + cnt) / (2 * cnt));
        res.green_out     = CH_W'((2 * sg + cnt) / (2 * cnt));
        res.blue_out      = CH_W'((2 * sb + cnt) / (2 * cnt));
        res.last_of_frame = (pos == pos_final);
        pending_blur.push_back(res);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            if (fail_count < REPORT_CAP)
                $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // monitor: check results, follow config writes, predict accepted items
    always @(posedge i_clk) begin
        t_pix_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++)
                win[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            cfg_width  = WIDTH_CFG_W'(WIDTH_RESET);
            cfg_height = HEIGHT_RESET;
            pending_blur.delete();
            in_fire <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_blur.size() == 0) begin
                    if (fail_count < REPORT_CAP)
                        $error("result item with no expected item waiting");
                    fail_count++;
                end else begin
                    want = pending_blur.pop_front();
                    check_field("red_out", want.red_out, o_data.red_out);
                    check_field("green_out", want.green_out, o_data.green_out);
                    check_field("blue_out", want.blue_out, o_data.blue_out);
                    check_field("last_of_frame", want.last_of_frame, o_data.last_of_frame);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_IMAGE_WIDTH) begin
                    cfg_width = i_cfg_data[WIDTH_CFG_W-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end else if (i_cfg_idx == REG_IMAGE_HEIGHT) begin
                    cfg_height = i_cfg_data[HEIGHT_CFG_W-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end
            end
            if (i_valid && o_ready) begin
                predict_blur(i_data);
                pixels_accepted++;
            end
            in_fire <= i_valid && o_ready;
        end
    end

    // driver: present queued items, hold until accepted, idle in bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_fire) begin
            // item still waiting for acceptance
        end else if (send_gap > 0) begin
            send_gap--;
            i_valid <= 1'b0;
        end else if (pixel_feed.size() > 0 &&
                     (!pixel_feed[0].hold_for_drain || pending_blur.size() == 0)) begin
            next_ent = pixel_feed.pop_front();
            i_data  <= next_ent.pix;
            i_valid <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 17);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            stall_left = LONG_STALL;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pix_in pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                      input logic [CH_W-1:0] b, input logic pad);
        t_pix_in p;
        p.red_in     = r;
        p.green_in   = g;
        p.blue_in    = b;
        p.is_padding = pad;
        return p;
    endfunction

    task automatic push_one(input t_pix_in pix, input bit hold);
        t_feed ent;
        ent.pix = pix;
        ent.hold_for_drain = hold;
        pixel_feed.push_back(ent);
        pixels_queued++;
    endtask

    // items [from, upto) of a w x h frame: pixels, then the drain items
    task automatic push_span(input int unsigned w, input int unsigned h,
                             input int unsigned from, input int unsigned upto);
        int unsigned i;
        for (i = from; i < upto; i++) begin
            if (i < w * h) begin
                push_one(pixel(rand_chan(), rand_chan(), rand_chan(),
                               $urandom_range(0, 15) == 0), $urandom_range(0, 59) == 0);
                frame_pixels++;
            end else begin
                push_one(pixel(rand_chan(), rand_chan(), rand_chan(),
                               $urandom_range(0, 7) != 0), $urandom_range(0, 59) == 0);
            end
        end
    endtask

    // wait until every item is in and every result out, then let the pipe settle
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pixels_accepted != pixels_queued || pending_blur.size() != 0);
        repeat (LAT_WAIT) @(negedge i_clk);
    endtask

    // called just after a falling edge with the write enable low
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned w, h, goal, nframes, f, stop, sel;
        bit first_rand;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: the first row and part of the second, with a sender pause
        @(posedge i_clk);
        push_span(WIDTH_RESET, HEIGHT_RESET, 0, 645);
        push_one(pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0), 1'b1);
        push_span(WIDTH_RESET, HEIGHT_RESET, 646, 650);

        // 3x3 frame of extreme values, padding inside the frame, pixels on drain items
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        @(posedge i_clk);
        push_one(pixel(8'd255, 8'd255, 8'd255, 1'b0), 1'b0);
        push_one(pixel(8'd0, 8'd0, 8'd0, 1'b0), 1'b0);
        push_one(pixel(8'd255, 8'd0, 8'd255, 1'b0), 1'b0);
        push_one(pixel(8'd0, 8'd255, 8'd0, 1'b0), 1'b0);
        push_one(pixel(8'd255, 8'd255, 8'd255, 1'b1), 1'b0);
        push_one(pixel(8'd1, 8'd128, 8'd254, 1'b0), 1'b0);
        push_one(pixel(8'd255, 8'd255, 8'd255, 1'b0), 1'b0);
        push_one(pixel(8'd127, 8'd128, 8'd129, 1'b0), 1'b0);
        push_one(pixel(8'd255, 8'd255, 8'd255, 1'b0), 1'b0);
        push_one(pixel(8'd0, 8'd0, 8'd0, 1'b1), 1'b0);
        push_one(pixel(8'd255, 8'd255, 8'd255, 1'b0), 1'b0);
        push_one(pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0), 1'b0);
        push_one(pixel(8'd255, 8'd255, 8'd255, 1'b1), 1'b0);

        // single-pixel frame, width written with the unused top data bit set; two frames
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'h1001);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        @(posedge i_clk);
        push_span(1, 1, 0, 3);
        push_span(1, 1, 0, 3);

        // zero height clamped to one: a full two-pixel frame
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd2);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        @(posedge i_clk);
        push_span(2, 1, 0, 5);

        // zero width clamped to one, height clamped to the row limit: a short partial frame
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        write_reg(REG_IMAGE_HEIGHT, 13'h1fff);
        @(posedge i_clk);
        push_span(1, ROW_CAP, 0, 24);

        // writes to unused indexes mid-frame leave the frame count alone
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd5);
        write_reg(REG_IMAGE_HEIGHT, 13'd4);
        @(posedge i_clk);
        push_span(5, 4, 0, 9);
        wait_idle();
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
        @(posedge i_clk);
        push_span(5, 4, 9, 26);

        // random phases: mostly small frames, some cut short, idling off near the end
        w = 5;
        h = 4;
        goal = frame_pixels + RAND_PIXELS;
        first_rand = 1'b1;
        while (frame_pixels < goal) begin
            wait_idle();
            if (first_rand) begin
                w = 8;
                h = 8;
                sel = 0;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: begin
                        w = $urandom_range(1, 10);
                        h = $urandom_range(1, 8);
                    end
                    7, 8: begin
                        w = $urandom_range(11, 40);
                        h = $urandom_range(1, 4);
                    end
                    default: begin
                        w = $urandom_range(100, 300);
                        h = $urandom_range(1, 2);
                    end
                endcase
                sel = $urandom_range(0, 5);
            end
            if (sel == 4)
                w = w;
            else
                write_reg(REG_IMAGE_WIDTH, {1'($urandom_range(0, 1)), WIDTH_CFG_W'(w)});
            if (sel == 3)
                h = h;
            else
                write_reg(REG_IMAGE_HEIGHT, HEIGHT_CFG_W'(h));
            if (sel == 5)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_DATA_W'($urandom));
            @(posedge i_clk);
            if (first_rand)
                hold_req++;
            first_rand = 1'b0;
            if (frame_pixels + CALM_TAIL >= goal)
                calm = 1'b1;
            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++) begin
                stop = w * h + w + 1;
                if (f == nframes - 1 && $urandom_range(0, 4) == 0)
                    stop = $urandom_range(1, stop - 1);
                push_span(w, h, 0, stop);
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
design/bb3_pkg.sv
design/bb3_ram.sv
design/bb3_scan.sv
design/bb3_line.sv
design/bb3_window.sv
design/bb3_avg.sv
design/box_blur_3x3_edge_clipped_top.sv
dv/tb_box_blur_3x3_edge_clipped_top.sv
